>>> src/rtt_pkg.sv
package rtt_pkg;

    localparam int TableEntriesDefault = 16;

    localparam int KeyW   = 32;
    localparam int TagW   = 16;
    localparam int TimerW = 8;
    localparam int RetryW = 8;
    localparam int KindW  = 3;
    localparam int OpW    = 2;

    // register file
    localparam int ApbAddrW  = 3;
    localparam int ApbDataW  = 32;
    localparam logic [TimerW-1:0] RetryIntervalReset = TimerW'(3);
    localparam logic [RetryW-1:0] RetryLimitReset    = RetryW'(2);
    localparam logic RegRetryLimit    = 1'b0;
    localparam logic RegRetryInterval = 1'b1;

    // operation codes
    localparam logic [OpW-1:0] OpAdd  = 2'd0;
    localparam logic [OpW-1:0] OpAck  = 2'd1;
    localparam logic [OpW-1:0] OpTick = 2'd2;

    // event kinds
    localparam logic [KindW-1:0] EvAdded    = 3'd0;
    localparam logic [KindW-1:0] EvFull     = 3'd1;
    localparam logic [KindW-1:0] EvAckHit   = 3'd2;
    localparam logic [KindW-1:0] EvAckMiss  = 3'd3;
    localparam logic [KindW-1:0] EvResend   = 3'd4;
    localparam logic [KindW-1:0] EvGiveUp   = 3'd5;
    localparam logic [KindW-1:0] EvTickDone = 3'd6;

    typedef struct packed {
        logic [OpW-1:0]  operation;
        logic [KeyW-1:0] packet_key;
        logic [TagW-1:0] buffer_tag;
    } t_in_word;

    typedef struct packed {
        logic [KindW-1:0] event_kind;
        logic [KeyW-1:0]  event_key;
        logic [TagW-1:0]  event_tag;
        logic             last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [KeyW-1:0]   key;
        logic [TagW-1:0]   tag;
        logic [TimerW-1:0] timer;
        logic [RetryW-1:0] retries;
    } t_entry;

endpackage

>>> src/retransmit_timer_table.sv
// retransmit timer table
//
// keeps the unacknowledged sent packets, oldest first, in a packed table
// channels: input words (add / ack / tick) on i_in_valid / o_in_ready,
// result words on o_out_valid / i_out_ready, registers on an apb-style port
// (retry_limit at 0x0, retry_interval at 0x4, pready always high)
// one word is worked on at a time; o_in_ready is high only while idle
// each word is walked through the table's one read port and one write port:
//   add            writes the new entry unless full, then loads its result word
//   ack            compares entry by entry; on a hit shifts younger entries down
//   tick           reads each stored entry in turn, then loads the tick-done word
// results go through one output register, so a new word is taken while the
// last result still waits; a stalled receiver holds the walk at its next result
// reset (synchronous, active low) empties the table and loads the register
// defaults (retry_limit 2, retry_interval 3); the table needs no clearing pass
module retransmit_timer_table #(
    parameter int TABLE_ENTRIES = rtt_pkg::TableEntriesDefault
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input words
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  rtt_pkg::t_in_word                  i_in_word,
    // result words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output rtt_pkg::t_out_word                 o_out_word,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rtt_pkg::ApbAddrW-1:0]       paddr,
    input  logic [rtt_pkg::ApbDataW-1:0]       pwdata,
    output logic [rtt_pkg::ApbDataW-1:0]       prdata,
    output logic                               pready
);
    import rtt_pkg::*;

    localparam int CntW = $clog2(TABLE_ENTRIES + 1);
    localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [CntW:0] FullCnt = (CntW + 1)'(TABLE_ENTRIES);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ADD      = 4'd1;
    localparam logic [3:0] S_ACK_RD   = 4'd2;
    localparam logic [3:0] S_ACK_CMP  = 4'd3;
    localparam logic [3:0] S_ACK_MISS = 4'd4;
    localparam logic [3:0] S_ACK_MRD  = 4'd5;
    localparam logic [3:0] S_ACK_MWR  = 4'd6;
    localparam logic [3:0] S_TICK_RD  = 4'd7;
    localparam logic [3:0] S_TICK_EV  = 4'd8;
    localparam logic [3:0] S_TICK_END = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [CntW-1:0]   r_count, n_count;   // entries stored, slots 0..count-1 live
    logic [CntW-1:0]   r_idx, n_idx;       // read pointer of the walk
    logic [CntW-1:0]   r_w, n_w;           // write pointer of the tick compaction
    t_in_word          r_cmd;
    logic [RetryW-1:0] r_retry_limit;
    logic [TimerW-1:0] r_retry_interval;

    // table memory, one read and one write port
    t_entry            r_mem [TABLE_ENTRIES];
    t_entry            r_rdata;
    logic              mem_re, mem_we;
    logic [IdxW-1:0]   mem_raddr, mem_waddr;
    t_entry            mem_wdata;

    // output register
    logic              r_out_valid;
    t_out_word         r_out;
    logic              out_free, out_load;
    t_out_word         out_word;

    logic              in_fire, cfg_wr;
    logic [CntW:0]     idx_p1, idx_p2, cnt_x;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid & o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign out_free    = ~r_out_valid | i_out_ready;

    assign idx_p1 = {1'b0, r_idx} + (CntW + 1)'(1);
    assign idx_p2 = {1'b0, r_idx} + (CntW + 1)'(2);
    assign cnt_x  = {1'b0, r_count};

    // register port, decoded on the word address bit only
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        prdata = '0;
        if (paddr[2] == RegRetryLimit) begin
            prdata[RetryW-1:0] = r_retry_limit;
        end else begin
            prdata[TimerW-1:0] = r_retry_interval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit    <= RetryLimitReset;
            r_retry_interval <= RetryIntervalReset;
        end else if (cfg_wr) begin
            if (paddr[2] == RegRetryLimit) begin
                r_retry_limit <= pwdata[RetryW-1:0];
            end else begin
                r_retry_interval <= pwdata[TimerW-1:0];
            end
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_w       = r_w;
        mem_re    = 1'b0;
        mem_raddr = r_idx[IdxW-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_w[IdxW-1:0];
        mem_wdata = r_rdata;
        out_load  = 1'b0;
        out_word  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_idx = '0;
                    n_w   = '0;
                    case (i_in_word.operation)
                        OpAdd:   n_state = S_ADD;
                        OpAck:   n_state = (r_count == '0) ? S_ACK_MISS : S_ACK_RD;
                        OpTick:  n_state = (r_count == '0) ? S_TICK_END : S_TICK_RD;
                        default: n_state = S_IDLE;   // unused code, no result
                    endcase
                end
            end

            S_ADD: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_word.event_key   = r_cmd.packet_key;
                    out_word.event_tag   = r_cmd.buffer_tag;
                    out_word.last_of_run = 1'b1;
                    if (cnt_x == FullCnt) begin
                        out_word.event_kind = EvFull;
                    end else begin
                        out_word.event_kind = EvAdded;
                        mem_we              = 1'b1;
                        mem_waddr           = r_count[IdxW-1:0];
                        mem_wdata.key       = r_cmd.packet_key;
                        mem_wdata.tag       = r_cmd.buffer_tag;
                        mem_wdata.timer     = r_retry_interval;
                        mem_wdata.retries   = r_retry_limit;
                        n_count             = r_count + CntW'(1);
                    end
                    n_state = S_IDLE;
                end
            end

            S_ACK_RD: begin
                mem_re  = 1'b1;
                n_state = S_ACK_CMP;
            end

            S_ACK_CMP: begin
                if (r_rdata.key == r_cmd.packet_key) begin
                    if (out_free) begin
                        out_load             = 1'b1;
                        out_word.event_kind  = EvAckHit;
                        out_word.event_key   = r_rdata.key;
                        out_word.event_tag   = r_rdata.tag;
                        out_word.last_of_run = 1'b1;
                        if (idx_p1 < cnt_x) begin
                            n_state = S_ACK_MRD;
                        end else begin
                            n_count = r_count - CntW'(1);
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    n_idx   = idx_p1[CntW-1:0];
                    n_state = (idx_p1 < cnt_x) ? S_ACK_RD : S_ACK_MISS;
                end
            end

            S_ACK_MISS: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_word.event_kind  = EvAckMiss;
                    out_word.event_key   = r_cmd.packet_key;
                    out_word.last_of_run = 1'b1;
                    n_state              = S_IDLE;
                end
            end

            // shift the younger entries down over the removed slot
            S_ACK_MRD: begin
                mem_re    = 1'b1;
                mem_raddr = idx_p1[IdxW-1:0];
                n_state   = S_ACK_MWR;
            end

            S_ACK_MWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[IdxW-1:0];
                n_idx     = idx_p1[CntW-1:0];
                if (idx_p2 < cnt_x) begin
                    n_state = S_ACK_MRD;
                end else begin
                    n_count = r_count - CntW'(1);
                    n_state = S_IDLE;
                end
            end

            S_TICK_RD: begin
                mem_re  = 1'b1;
                n_state = S_TICK_EV;
            end

            S_TICK_EV: begin
                if (r_rdata.timer != '0) begin
                    mem_we          = 1'b1;
                    mem_wdata.timer = r_rdata.timer - TimerW'(1);
                    n_w             = r_w + CntW'(1);
                    n_idx           = idx_p1[CntW-1:0];
                    n_state         = (idx_p1 < cnt_x) ? S_TICK_RD : S_TICK_END;
                end else if (out_free) begin
                    out_load           = 1'b1;
                    out_word.event_key = r_rdata.key;
                    out_word.event_tag = r_rdata.tag;
                    if (r_rdata.retries != '0) begin
                        out_word.event_kind = EvResend;
                        mem_we              = 1'b1;
                        mem_wdata.retries   = r_rdata.retries - RetryW'(1);
                        mem_wdata.timer     = r_retry_interval;
                        n_w                 = r_w + CntW'(1);
                    end else begin
                        out_word.event_kind = EvGiveUp;   // entry dropped
                    end
                    n_idx   = idx_p1[CntW-1:0];
                    n_state = (idx_p1 < cnt_x) ? S_TICK_RD : S_TICK_END;
                end
            end

            S_TICK_END: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_word.event_kind  = EvTickDone;
                    out_word.last_of_run = 1'b1;
                    n_count              = r_w;
                    n_state              = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_w     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_w     <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_in_word;
        end
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_word;
        end
    end

    // never more entries than slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_x <= FullCnt)
        else $error("entry count above table size");

    // compaction write pointer never passes the read pointer
    a_tick_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK_EV) |-> (r_w <= r_idx))
        else $error("tick write pointer ahead of read pointer");

    // shifting on an ack only reads live slots
    a_ack_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACK_MRD) |-> (idx_p1 < cnt_x))
        else $error("ack shift reads past the last entry");

    // the table does not change size while idle
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> (r_count == $past(r_count)))
        else $error("entry count changed while idle");

    // a word is only loaded into a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result word overwritten");

endmodule

>>> tb/retransmit_timer_table_tb.sv
module retransmit_timer_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtt_pkg::*;

    // operation code the block drops without a result
    localparam logic [OpW-1:0] OpIgnored = 2'd3;

    localparam int TableEntries  = TableEntriesDefault;
    localparam int SettleCycles  = 60;    // room for the longest walk to finish
    localparam int HoldOffCycles = 200;   // long receiver stall to back up the input
    localparam int WatchdogLimit = 2000;  // cycles with no handshake at all
    localparam int PrintCap      = 50;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    // input word channel
    logic     in_valid = 1'b0;
    logic     in_ready;
    t_in_word in_word  = '0;
    logic     in_taken = 1'b0;

    // result word channel
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    // register port
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ApbAddrW-1:0] paddr   = '0;
    logic [ApbDataW-1:0] pwdata  = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    retransmit_timer_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // words waiting for the driver, results waiting for the monitor
    t_in_word  word_backlog[$];
    t_out_word expected_events[$];

    // shadow of the block: registers and the packed table, slot 0 oldest
    logic [RetryW-1:0] cfg_retry_limit    = RetryLimitReset;
    logic [TimerW-1:0] cfg_retry_interval = RetryIntervalReset;
    t_entry            unacked [TableEntries];
    int                unacked_count = 0;

    // keys reused so that acks find their entries
    logic [KeyW-1:0] key_pool [8];

    // idling control
    bit quiet_tail    = 1'b0;
    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;
    int send_gap  = 0;
    int send_calm = 0;
    int recv_gap  = 0;
    int recv_calm = 0;
    int hold_left = 0;

    // bookkeeping
    int mismatch_count  = 0;
    int words_taken     = 0;
    int results_checked = 0;
    int resends_seen    = 0;
    int give_ups_seen   = 0;
    int rejects_seen    = 0;
    int stall_cycles    = 0;

    task automatic flag_mismatch(input string what);
        if (mismatch_count < PrintCap) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    function automatic t_out_word result_word(input logic [KindW-1:0] kind,
                                              input logic [KeyW-1:0] key,
                                              input logic [TagW-1:0] tag,
                                              input logic last);
        t_out_word r;
        r.event_kind  = kind;
        r.event_key   = key;
        r.event_tag   = tag;
        r.last_of_run = last;
        return r;
    endfunction

    // expected results of one accepted word, and the table update it causes
    task automatic predict_events(input t_in_word w);
        int     hit;
        int     keep;
        t_entry e;
        case (w.operation)
            OpAdd: begin
                if (unacked_count >= TableEntries) begin
                    expected_events.push_back(result_word(EvFull, w.packet_key,
                                                          w.buffer_tag, 1'b1));
                end else begin
                    e.key     = w.packet_key;
                    e.tag     = w.buffer_tag;
                    e.timer   = cfg_retry_interval;
                    e.retries = cfg_retry_limit;
                    unacked[unacked_count] = e;
                    unacked_count++;
                    expected_events.push_back(result_word(EvAdded, w.packet_key,
                                                          w.buffer_tag, 1'b1));
                end
            end
            OpAck: begin
                // oldest matching entry wins
                hit = -1;
                for (int i = 0; i < unacked_count; i++) begin
                    if (hit < 0 && unacked[i].key == w.packet_key) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    expected_events.push_back(result_word(EvAckHit, unacked[hit].key,
                                                          unacked[hit].tag, 1'b1));
                    for (int j = hit; j < unacked_count - 1; j++) begin
                        unacked[j] = unacked[j + 1];
                    end
                    unacked_count--;
                end else begin
                    expected_events.push_back(result_word(EvAckMiss, w.packet_key,
                                                          '0, 1'b1));
                end
            end
            OpTick: begin
                // walk oldest first, compacting the survivors
                keep = 0;
                for (int i = 0; i < unacked_count; i++) begin
                    e = unacked[i];
                    if (e.timer != 0) begin
                        e.timer--;
                    end else if (e.retries != 0) begin
                        e.retries--;
                        e.timer = cfg_retry_interval;
                        expected_events.push_back(result_word(EvResend, e.key, e.tag, 1'b0));
                    end else begin
                        expected_events.push_back(result_word(EvGiveUp, e.key, e.tag, 1'b0));
                        continue;
                    end
                    unacked[keep] = e;
                    keep++;
                end
                unacked_count = keep;
                expected_events.push_back(result_word(EvTickDone, '0, '0, 1'b1));
            end
            default: begin
                // ignored operation: no result, no change
            end
        endcase
    endtask

    // input driver: changes at the falling edge, holds a word until taken
    always @(negedge clk) begin : drive_words
        logic     next_valid;
        t_in_word next_word;
        next_valid = in_valid;
        next_word  = in_word;
        if (!in_valid || in_taken) begin
            next_valid = 1'b0;
            if (send_gap != 0) begin
                send_gap--;
            end else if (word_backlog.size() != 0) begin
                if (!quiet_tail && send_calm == 0 && $urandom_range(0, 5) == 0) begin
                    // idle burst, then a calm stretch
                    send_gap  = $urandom_range(0, 9);
                    send_calm = $urandom_range(0, 40);
                end else begin
                    if (send_calm != 0) begin
                        send_calm--;
                    end
                    next_valid = 1'b1;
                    next_word  = word_backlog.pop_front();
                end
            end
        end
        in_valid <= next_valid;
        in_word  <= next_word;
    end

    // receiver ready: random stall bursts plus one long hold-off
    always @(negedge clk) begin : drive_ready
        logic next_ready;
        next_ready = 1'b1;
        if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_left     = HoldOffCycles - 1;
            next_ready    = 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            next_ready = 1'b0;
        end else if (!quiet_tail && recv_calm == 0 && $urandom_range(0, 5) == 0) begin
            recv_gap   = $urandom_range(0, 9);
            recv_calm  = $urandom_range(0, 40);
            next_ready = 1'b0;
        end else if (recv_calm != 0) begin
            recv_calm--;
        end
        out_ready <= next_ready;
    end

    // monitor: handshakes at the rising edge, prediction, checking, watchdog
    always @(posedge clk) begin : watch_channels
        t_out_word want;
        in_taken <= in_valid && in_ready;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                predict_events(in_word);
                words_taken++;
            end
            if (out_valid && out_ready) begin
                results_checked++;
                case (out_word.event_kind)
                    EvResend: resends_seen++;
                    EvGiveUp: give_ups_seen++;
                    EvFull:   rejects_seen++;
                    default:  ;
                endcase
                if (expected_events.size() == 0) begin
                    flag_mismatch($sformatf("result with nothing expected: kind %0d key %h",
                                            out_word.event_kind, out_word.event_key));
                end else begin
                    want = expected_events.pop_front();
                    if (out_word.event_kind !== want.event_kind) begin
                        flag_mismatch($sformatf("event_kind %0d, expected %0d",
                                                out_word.event_kind, want.event_kind));
                    end
                    if (out_word.event_key !== want.event_key) begin
                        flag_mismatch($sformatf("event_key %h, expected %h (kind %0d)",
                                                out_word.event_key, want.event_key,
                                                want.event_kind));
                    end
                    if (out_word.event_tag !== want.event_tag) begin
                        flag_mismatch($sformatf("event_tag %h, expected %h (kind %0d)",
                                                out_word.event_tag, want.event_tag,
                                                want.event_kind));
                    end
                    if (out_word.last_of_run !== want.last_of_run) begin
                        flag_mismatch($sformatf("last_of_run %b, expected %b (kind %0d)",
                                                out_word.last_of_run, want.last_of_run,
                                                want.event_kind));
                    end
                end
            end
        end
        // any handshake, register access included, counts as progress
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WatchdogLimit) begin
            $display("watchdog: no progress for %0d cycles", WatchdogLimit);
            $display("retransmit_timer_table_tb: errors");
            $finish;
        end
    end

    // apb write, then read back; the shadow copy follows the write
    task automatic write_register(input logic reg_index, input logic [7:0] value);
        logic [ApbDataW-1:0] readback;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= {24'($urandom), value};  // upper bits are not stored
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_index == RegRetryLimit) begin
            cfg_retry_limit = value;
        end else begin
            cfg_retry_interval = value;
        end
        @(negedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[7:0] !== value) begin
            flag_mismatch($sformatf("register %0d reads %h, expected %h",
                                    reg_index, readback[7:0], value));
        end
    endtask

    // wait until every word is in and every result out, then let a walk finish
    task automatic drain_block();
        while (word_backlog.size() != 0 || in_valid || expected_events.size() != 0) begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic queue_word(input logic [OpW-1:0] op, input logic [KeyW-1:0] key,
                              input logic [TagW-1:0] tag);
        t_in_word w;
        w.operation  = op;
        w.packet_key = key;
        w.buffer_tag = tag;
        word_backlog.push_back(w);
    endtask

    // mostly adds and acks on a small key pool, some ticks, a little noise
    task automatic queue_random_words(input int count);
        int              queued;
        int              pick;
        logic [OpW-1:0]  op;
        logic [KeyW-1:0] key;
        for (int i = 0; i < 8; i++) begin
            key_pool[i] = KeyW'($urandom);
        end
        queued = 0;
        while (queued < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                op = OpAdd;
            end else if (pick < 75) begin
                op = OpAck;
            end else if (pick < 95) begin
                op = OpTick;
            end else begin
                op = OpIgnored;
            end
            if ($urandom_range(0, 99) < 85) begin
                key = key_pool[$urandom_range(0, 7)];
            end else begin
                key = KeyW'($urandom);
            end
            queue_word(op, key, TagW'($urandom));
            if (op != OpIgnored) begin
                queued++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register defaults: limit 2, interval 3
        queue_random_words(80);
        drain_block();

        // directed: one retry, no wait, so two ticks resend then give up
        write_register(RegRetryLimit, 8'd1);
        write_register(RegRetryInterval, 8'd0);
        queue_word(OpTick, KeyW'($urandom), TagW'($urandom));
        queue_word(OpIgnored, KeyW'($urandom), TagW'($urandom));
        queue_word(OpAdd, '0, '0);
        queue_word(OpAdd, '1, '1);
        queue_word(OpAck, 32'h1357_9bdf, TagW'($urandom));     // no match
        queue_word(OpAck, '1, '0);                             // match
        queue_word(OpAdd, '0, 16'h1234);                       // duplicate key
        queue_word(OpAck, '0, '1);                             // oldest duplicate goes
        for (int i = 0; i < TableEntries - 1; i++) begin
            queue_word(OpAdd, KeyW'($urandom), TagW'($urandom));
        end
        queue_word(OpAdd, KeyW'($urandom), TagW'($urandom));   // table full
        queue_word(OpTick, '0, '0);                            // resend every directed entry
        queue_word(OpTick, '0, '0);                            // give up every directed entry
        drain_block();

        // low extremes: nothing survives its first expiry
        write_register(RegRetryLimit, 8'd0);
        write_register(RegRetryInterval, 8'd0);
        queue_random_words(70);
        drain_block();

        // high extremes: entries stay, the table fills
        write_register(RegRetryLimit, 8'd255);
        write_register(RegRetryInterval, 8'd255);
        queue_random_words(60);
        drain_block();

        // short timers with a long receiver stall in the middle
        write_register(RegRetryLimit, 8'($urandom_range(1, 3)));
        write_register(RegRetryInterval, 8'($urandom_range(0, 3)));
        hold_off_req = 1'b1;
        queue_random_words(70);
        drain_block();

        // last stretch at full rate on both sides
        write_register(RegRetryLimit, 8'($urandom_range(1, 3)));
        write_register(RegRetryInterval, 8'($urandom_range(0, 2)));
        quiet_tail = 1'b1;
        queue_random_words(70);
        drain_block();

        $display("covered %0d words and %0d results over six register settings",
                 words_taken, results_checked);
        $display("  including %0d resends, %0d give-ups and %0d full-table rejects",
                 resends_seen, give_ups_seen, rejects_seen);
        if (mismatch_count == 0) begin
            $display("retransmit_timer_table_tb: clean");
        end else begin
            $display("retransmit_timer_table_tb: errors");
        end
        $finish;
    end

endmodule

>>> retransmit_timer_table.f
src/rtt_pkg.sv
src/retransmit_timer_table.sv
tb/retransmit_timer_table_tb.sv
